### hdl/sci_pkg.sv
package sci_pkg;

  localparam logic [5:0] OP_ADD   = 6'h01;
  localparam logic [5:0] OP_SUB   = 6'h03;
  localparam logic [5:0] OP_MUL   = 6'h05;
  localparam logic [5:0] OP_DIV   = 6'h07;
  localparam logic [5:0] OP_MOD   = 6'h09;
  localparam logic [5:0] OP_AND   = 6'h0B;
  localparam logic [5:0] OP_OR    = 6'h0D;
  localparam logic [5:0] OP_XOR   = 6'h0F;
  localparam logic [5:0] OP_JMP   = 6'h10;
  localparam logic [5:0] OP_JZ    = 6'h11;
  localparam logic [5:0] OP_JO    = 6'h12;
  localparam logic [5:0] OP_JZO   = 6'h13;
  localparam logic [5:0] OP_JNZ   = 6'h15;
  localparam logic [5:0] OP_JNZO  = 6'h17;
  localparam logic [5:0] OP_LOAD  = 6'h20;
  localparam logic [5:0] OP_STORE = 6'h21;
  localparam logic [5:0] OP_RECV  = 6'h22;
  localparam logic [5:0] OP_SEND  = 6'h23;
  localparam logic [5:0] OP_CMPEQ = 6'h31;
  localparam logic [5:0] OP_CMPBL = 6'h33;
  localparam logic [5:0] OP_CMPLT = 6'h37;
  localparam logic [5:0] OP_CMPNE = 6'h39;
  localparam logic [5:0] OP_CMPAE = 6'h3B;
  localparam logic [5:0] OP_CMPGE = 6'h3F;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DIVZ   = 3'd1;
  localparam logic [2:0] ST_BADOP  = 3'd2;
  localparam logic [2:0] ST_RANGE  = 3'd3;
  localparam logic [2:0] ST_HALTED = 3'd4;

  localparam logic [1:0] IO_NONE = 2'd0;
  localparam logic [1:0] IO_RECV = 2'd1;
  localparam logic [1:0] IO_SEND = 2'd2;

  localparam logic CFG_PROGRAM_LENGTH = 1'b0;
  localparam logic CFG_START_ADDRESS  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic decode;     // latch item
    logic exec;       // read registers, latch operands and product, set memory read address
    logic div_start;
    logic div_step;
    logic finish;     // write back, form result
    logic mem_clear;  // clearing pass write
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_div;
    logic is_load;
    logic div_done;
  } stat_t;

endpackage

### hdl/sci_ram.sv
module sci_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hdl/sci_ctrl.sv
module sci_ctrl #(
  parameter int MEM_ADDR_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  input  sci_pkg::stat_t           stat,
  output sci_pkg::cmd_t            cmd,
  output logic [MEM_ADDR_BITS-1:0] clr_addr
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state, state_next;
  logic       out_valid_next;
  logic       take, fin;

  // input taken only when idle and no result pending (one item at a time)
  assign in_stall = (state != S_IDLE) || out_valid;
  assign take     = in_valid && !in_stall;
  assign fin      = (state == S_FIN);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (&clr_addr) state_next = S_IDLE;
      S_IDLE:  if (take) state_next = S_EXEC;
      S_EXEC:  if (stat.is_div) state_next = S_DIV;
               else if (stat.is_load) state_next = S_WAIT;
               else state_next = S_FIN;
      S_DIV:   if (stat.div_done) state_next = S_FIN;
      S_WAIT:  state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.decode    = take;
    cmd.exec      = (state == S_EXEC);
    cmd.div_start = (state == S_EXEC) && stat.is_div;
    cmd.div_step  = (state == S_DIV) && !stat.div_done;
    cmd.finish    = fin;
    cmd.mem_clear = (state == S_CLEAR);
  end

  assign out_valid_next = fin ? 1'b1 : (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
      clr_addr  <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    take |-> !out_valid) else $error("item taken while result pending");
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    fin |=> out_valid) else $error("result not shown after finish");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !take) else $error("item taken while busy");
endmodule

### hdl/sci_dp.sv
module sci_dp #(
  parameter int MEM_ADDR_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sci_pkg::cmd_t            cmd,
  output sci_pkg::stat_t           stat,
  input  logic [MEM_ADDR_BITS-1:0] clr_addr,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic                     cfg_hit,
  input  logic [15:0]              cfg_data,
  input  logic [31:0]              instruction_word,
  input  logic [15:0]              receive_data,
  output logic [15:0]              next_address,
  output logic [2:0]               status,
  output logic [1:0]               io_kind,
  output logic [15:0]              io_port,
  output logic [15:0]              send_value
);
  logic [15:0] regs [15];
  logic [15:0] pc, prog_len;
  logic        stopped;
  logic [31:0] w;
  logic [15:0] rx, a1, a2, ra1, ra2;
  logic [5:0]  op;
  logic [3:0]  dst;
  logic [15:0] wb_val;
  logic        wb_en;
  logic [15:0] mul_q;
  logic [15:0] rdata;
  logic        mem_we;
  logic [MEM_ADDR_BITS-1:0] mem_waddr;
  logic [15:0] mem_wdata;
  logic [15:0] dq, dr;
  logic [4:0]  dn;
  logic [16:0] dt;

  assign op  = w[5:0];
  assign dst = w[11:8];

  always_comb begin
    ra1 = (w[15:12] == 4'd0) ? 16'd0 : regs[w[15:12] - 4'd1];
    ra2 = (w[31:28] == 4'd0) ? 16'd0 : regs[w[31:28] - 4'd1];
  end

  // item latched at decode, operands registered at exec
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      w  <= instruction_word;
      rx <= receive_data;
    end
    if (cmd.exec) begin
      a1    <= w[6] ? ra1 : w[27:12];
      a2    <= w[7] ? ra2 : w[31:16];
      mul_q <= 16'((w[6] ? ra1 : w[27:12]) * (w[7] ? ra2 : w[31:16]));
    end
  end

  assign stat.is_div   = (op == sci_pkg::OP_DIV) || (op == sci_pkg::OP_MOD);
  assign stat.is_load  = (op == sci_pkg::OP_LOAD);
  assign stat.div_done = (dn == 5'd16);

  // restoring divide, one bit a cycle; a2 is valid once exec is past
  assign dt = {dr, dq[15]} - {1'b0, a2};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dn <= 5'd0;
      dq <= w[6] ? ra1 : w[27:12];
      dr <= 16'd0;
    end else if (cmd.div_step) begin
      dn <= dn + 5'd1;
      dq <= {dq[14:0], !dt[16]};
      dr <= dt[16] ? {dr[14:0], dq[15]} : dt[15:0];
    end
  end

  always_comb begin
    wb_en  = 1'b1;
    wb_val = 16'd0;
    case (op)
      sci_pkg::OP_ADD:   wb_val = a1 + a2;
      sci_pkg::OP_SUB:   wb_val = a1 - a2;
      sci_pkg::OP_MUL:   wb_val = mul_q;
      sci_pkg::OP_DIV:   wb_val = (a2 == 16'd0) ? 16'd0 : dq;
      sci_pkg::OP_MOD:   wb_val = (a2 == 16'd0) ? 16'd0 : dr;
      sci_pkg::OP_AND:   wb_val = a1 & a2;
      sci_pkg::OP_OR:    wb_val = a1 | a2;
      sci_pkg::OP_XOR:   wb_val = a1 ^ a2;
      sci_pkg::OP_CMPEQ: wb_val = {15'd0, a1 == a2};
      sci_pkg::OP_CMPNE: wb_val = {15'd0, a1 != a2};
      sci_pkg::OP_CMPBL: wb_val = {15'd0, a1 < a2};
      sci_pkg::OP_CMPAE: wb_val = {15'd0, a1 >= a2};
      sci_pkg::OP_CMPLT: wb_val = {15'd0, $signed(a1) < $signed(a2)};
      sci_pkg::OP_CMPGE: wb_val = {15'd0, $signed(a1) >= $signed(a2)};
      sci_pkg::OP_LOAD:  wb_val = rdata;
      sci_pkg::OP_RECV:  wb_val = rx;
      default:           wb_en  = 1'b0;
    endcase
  end

  assign mem_we    = cmd.mem_clear ||
                     (cmd.finish && !stopped && pc < prog_len && op == sci_pkg::OP_STORE);
  assign mem_waddr = cmd.mem_clear ? clr_addr : a1[MEM_ADDR_BITS-1:0];
  assign mem_wdata = cmd.mem_clear ? 16'd0 : a2;

  sci_ram #(.WIDTH(16), .DEPTH(1 << MEM_ADDR_BITS)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(a1[MEM_ADDR_BITS-1:0]), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= 16'd0;
      prog_len <= 16'hFFFF;
      stopped  <= 1'b0;
      for (int i = 0; i < 15; i++) regs[i] <= 16'd0;
    end else if (cfg_write && cfg_hit) begin
      if (cfg_index == sci_pkg::CFG_PROGRAM_LENGTH) prog_len <= cfg_data;
      else pc <= cfg_data;
    end else if (cmd.finish) begin
      io_kind    <= sci_pkg::IO_NONE;
      io_port    <= 16'd0;
      send_value <= 16'd0;
      status     <= sci_pkg::ST_OK;
      if (stopped) begin
        status       <= sci_pkg::ST_HALTED;
        next_address <= pc;
      end else if (pc >= prog_len) begin
        stopped      <= 1'b1;
        status       <= sci_pkg::ST_RANGE;
        next_address <= pc;
      end else begin
        logic [15:0] npc;
        npc = pc + 16'd1;
        case (op)
          sci_pkg::OP_JMP:  npc = a1;
          sci_pkg::OP_JO:   npc = pc + a1;
          sci_pkg::OP_JZ:   if (a2 == 16'd0) npc = a1;
          sci_pkg::OP_JZO:  if (a2 == 16'd0) npc = pc + a1;
          sci_pkg::OP_JNZ:  if (a2 != 16'd0) npc = a1;
          sci_pkg::OP_JNZO: if (a2 != 16'd0) npc = pc + a1;
          sci_pkg::OP_DIV, sci_pkg::OP_MOD:
            if (a2 == 16'd0) status <= sci_pkg::ST_DIVZ;
          sci_pkg::OP_RECV: begin
            io_kind <= sci_pkg::IO_RECV;
            io_port <= a1;
          end
          sci_pkg::OP_SEND: begin
            io_kind    <= sci_pkg::IO_SEND;
            io_port    <= a1;
            send_value <= a2;
          end
          sci_pkg::OP_ADD, sci_pkg::OP_SUB, sci_pkg::OP_MUL, sci_pkg::OP_AND,
          sci_pkg::OP_OR, sci_pkg::OP_XOR, sci_pkg::OP_CMPEQ, sci_pkg::OP_CMPNE,
          sci_pkg::OP_CMPBL, sci_pkg::OP_CMPAE, sci_pkg::OP_CMPLT,
          sci_pkg::OP_CMPGE, sci_pkg::OP_LOAD, sci_pkg::OP_STORE: ;
          default: begin
            stopped <= 1'b1;
            status  <= sci_pkg::ST_BADOP;
          end
        endcase
        pc           <= npc;
        next_address <= npc;
        if (wb_en && dst != 4'd0) regs[dst - 4'd1] <= wb_val;
      end
    end
  end

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> ##16 stat.div_done) else $error("divide length wrong");
  a_clear_only: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_clear |-> !cmd.finish) else $error("finish during clear");
  a_stop_hold: assert property (@(posedge clk) disable iff (rst)
    (stopped && !(cfg_write && cfg_hit)) |=> $stable(pc))
    else $error("pc moved while stopped");
endmodule

### hdl/small_cpu_instruction_execute.sv
// channel  | direction | handshake            | payload
// input    | in        | in_valid / in_stall  | instruction_word, receive_data
// output   | out       | out_valid / out_stall| next_address, status, io_kind, io_port, send_value
// config   | in        | cfg_write            | cfg_index, cfg_data
// an item passes exec and finish; load adds a wait state, div or mod the bit-serial divider (16 steps)
// next item is taken once the result has been delivered
// after reset a clearing pass over all 2**MEM_ADDR_BITS words zeroes data memory; no item taken
// output stall holds the result and blocks the next item
module small_cpu_instruction_execute #(
  parameter int MEM_ADDR_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instruction_word,
  input  logic [15:0] receive_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] next_address,
  output logic [2:0]  status,
  output logic [1:0]  io_kind,
  output logic [15:0] io_port,
  output logic [15:0] send_value,
  input  logic        cfg_write,
  input  logic [15:0] cfg_index,
  input  logic [15:0] cfg_data
);
  sci_pkg::cmd_t  cmd;
  sci_pkg::stat_t stat;
  logic [MEM_ADDR_BITS-1:0] clr_addr;

  sci_ctrl #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd),
    .clr_addr(clr_addr)
  );

  sci_dp #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .clr_addr(clr_addr),
    .cfg_write(cfg_write), .cfg_index(cfg_index[0]),
    .cfg_hit(cfg_index[15:1] == 15'd0), .cfg_data(cfg_data),
    .instruction_word(instruction_word), .receive_data(receive_data),
    .next_address(next_address), .status(status), .io_kind(io_kind),
    .io_port(io_port), .send_value(send_value)
  );
endmodule
